FILE: hdl/iol_pkg.sv
// Shared types and constants for the indexed ordered list.
package iol_pkg;

  // Width of positions and counts inside the cell row; covers a list of up to 2047 entries.
  localparam int unsigned CNT_W = 11;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_INSERT = 3'd1,
    OP_APPEND = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         length;
  } rsp_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic               ins;
    logic               app;
    logic               del;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   held;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

FILE: hdl/indexed_ordered_list.sv
// Top level of the indexed ordered list: a row of value cells plus count and result logic.
//
// Usage: drive req_i and raise start_i; a request is taken at each rising edge
// where start_i is high and busy_o is low. busy_o stays low, so one transaction
// is taken every cycle. Requests: get, insert before a position, append, delete
// at a position, clear.
// Each transaction returns one result on rsp_o, marked by done_o for exactly one
// cycle; the result passes a first register stage and then the output register.
// The receiver cannot stall; results are never held back.
// Insert and delete shift every later entry by one place in the same cycle in
// the cell row, so the count and contents seen by the next transaction are
// already up to date. A get reads through a registered per-cell mask and an OR
// over all cells, which feeds the output register.
// Reset clears the count and the result strobe; stored values are not cleared,
// only entries below the count are ever read.
module indexed_ordered_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  iol_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output iol_pkg::rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] held_d, held_q;
  iol_pkg::cell_cmd_t cmd;
  logic signed [31:0] vals [CAPACITY];
  logic signed [31:0] hits [CAPACITY];

  logic       accept;
  logic       full, in_range;
  logic [1:0] status_d, status_q;
  logic       get_ok_d, get_ok_q, get_bad_d, get_bad_q;
  logic       v1_d, v1_q;
  logic [6:0] len_q;
  logic signed [31:0] rd_or;
  iol_pkg::rsp_t rsp_d, rsp_q;
  logic       done_q;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign full     = held_q >= CW'(CAPACITY);
  assign in_range = iol_pkg::CNT_W'(req_i.position) < iol_pkg::CNT_W'(held_q);

  always_comb begin
    held_d    = held_q;
    status_d  = iol_pkg::ST_OK;
    get_ok_d  = 1'b0;
    get_bad_d = 1'b0;
    cmd.ins   = 1'b0;
    cmd.app   = 1'b0;
    cmd.del   = 1'b0;
    cmd.pos   = iol_pkg::CNT_W'(req_i.position);
    cmd.held  = iol_pkg::CNT_W'(held_q);
    cmd.value = req_i.item_value;
    v1_d      = accept;
    if (accept) begin
      unique case (req_i.op)
        iol_pkg::OP_GET: begin
          if (in_range) begin
            get_ok_d = 1'b1;
          end else begin
            get_bad_d = 1'b1;
            status_d  = iol_pkg::ST_RANGE;
          end
        end
        iol_pkg::OP_INSERT: begin
          if (req_i.position != '0 && !in_range) begin
            status_d = iol_pkg::ST_RANGE;
          end else if (full) begin
            status_d = iol_pkg::ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            held_d  = held_q + 1'b1;
          end
        end
        iol_pkg::OP_APPEND: begin
          if (full) begin
            status_d = iol_pkg::ST_FULL;
          end else begin
            cmd.app = 1'b1;
            held_d  = held_q + 1'b1;
          end
        end
        iol_pkg::OP_DELETE: begin
          if (!in_range) begin
            status_d = iol_pkg::ST_RANGE;
          end else begin
            cmd.del = 1'b1;
            held_d  = held_q - 1'b1;
          end
        end
        iol_pkg::OP_CLEAR: begin
          held_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = vals[i];
    end else begin : g_mid_l
      assign left_w = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = vals[i];
    end else begin : g_mid_r
      assign right_w = vals[i+1];
    end
    iol_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_w),
      .right_i(right_w),
      .value_o(vals[i]),
      .hit_o  (hits[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | hits[i];
    end
    rsp_d.status     = status_q;
    rsp_d.length     = len_q;
    rsp_d.read_value = get_ok_q ? rd_or : (get_bad_q ? -32'sd1 : 32'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      held_q <= held_d;
      v1_q   <= v1_d;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    get_ok_q  <= get_ok_d;
    get_bad_q <= get_bad_d;
    len_q     <= 7'(held_d);
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: hdl/iol_cell.sv
// One list entry: holds a value and shifts with its neighbors on insert or delete.
module iol_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk_i,
  input  iol_pkg::cell_cmd_t       cmd_i,
  input  logic signed [31:0]       left_i,
  input  logic signed [31:0]       right_i,
  output logic signed [31:0]       value_o,
  output logic signed [31:0]       hit_o
);

  localparam logic [iol_pkg::CNT_W-1:0] MyIdx = iol_pkg::CNT_W'(IDX);

  logic signed [31:0] value_d, value_q;
  logic signed [31:0] hit_d, hit_q;

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (MyIdx == cmd_i.pos) begin
        value_d = cmd_i.value;
      end else if (MyIdx > cmd_i.pos) begin
        value_d = left_i;
      end
    end else if (cmd_i.app) begin
      if (MyIdx == cmd_i.held) begin
        value_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= cmd_i.pos) begin
        value_d = right_i;
      end
    end
    // masked read: only the addressed cell contributes to the OR
    hit_d = (MyIdx == cmd_i.pos) ? value_q : '0;
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    hit_q   <= hit_d;
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule
